// ===== rtl/ucm_pkg.sv =====
`timescale 1ns / 1ps
package ucm_pkg;
	localparam int unsigned PctScale = 100;
	localparam int unsigned RateMax = 65535;
	// ceil(2^38 / 1000): floor(x / 1000) = (x * MbpsRecip) >> 38 for any 32-bit x
	localparam logic [28:0] MbpsRecip = 29'd274877907;
	localparam logic [6:0] ThresholdReset = 7'd80;
	localparam logic [19:0] CapacityReset = 20'd100;
	localparam logic [0:0] RegThreshold = 1'b0;
	localparam logic [0:0] RegCapacity = 1'b1;

	typedef struct packed {
		logic        cpu_valid;
		logic [63:0] cpu_busy_count;
		logic [63:0] cpu_total_count;
		logic        disk_valid;
		logic [63:0] disk_busy_ms;
		logic        net_valid;
		logic [63:0] net_byte_count;
		logic [63:0] now_ms;
		logic [19:0] link_speed_mbps;
	} sample_t;

	typedef struct packed {
		logic        report_valid;
		logic [6:0]  cpu_pct;
		logic        cpu_hot;
		logic [6:0]  disk_busy_pct;
		logic        disk_hot;
		logic [15:0] net_rate;
		logic        net_hot;
	} report_t;

	// which division the shared divider runs
	typedef enum logic [1:0] {
		DIV_CPU  = 2'd0,
		DIV_DISK = 2'd1,
		DIV_NET  = 2'd2
	} div_sel_t;

	typedef struct packed {
		logic     load;
		logic     div_start;
		div_sel_t div_sel;
		logic     div_store;
		logic     scale;
		logic     finish;
	} ucm_cmd_t;

	typedef struct packed {
		logic div_done;
	} ucm_sts_t;
endpackage

// ===== rtl/ucm_div.sv =====
`timescale 1ns / 1ps
// restoring divider, 128-bit dividend by 64-bit divisor, one bit a cycle
module ucm_div (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [127:0] dividend,
	input  logic [63:0]  divisor,
	output logic         done,
	output logic [127:0] quotient
);
	logic [127:0] num_q;
	logic [63:0]  rem_q;
	logic [63:0]  den_q;
	logic [6:0]   cnt_q;
	logic         busy_q;
	logic [64:0]  shifted;
	logic [65:0]  diff;
	logic         take;

	assign shifted = {rem_q, num_q[127]};
	assign diff = {1'b0, shifted} - {2'b00, den_q};
	assign take = rem_q[63] | ~diff[65];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd127) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[126:0], take};
			rem_q <= take ? diff[63:0] : shifted[63:0];
		end
	end
	assign quotient = num_q;
endmodule

// ===== rtl/ucm_datapath.sv =====
`timescale 1ns / 1ps
module ucm_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  ucm_pkg::ucm_cmd_t cmd,
	output ucm_pkg::ucm_sts_t sts,
	input  ucm_pkg::sample_t  sample,
	input  logic [6:0]        threshold,
	input  logic [19:0]       capacity,
	output ucm_pkg::report_t  report
);
	logic        any_primed_q, cpu_primed_q, disk_primed_q, net_primed_q;
	logic [63:0] cpu_busy_base_q, cpu_total_base_q, disk_base_q, net_base_q, last_time_q;
	logic [63:0] d_busy_q, d_total_q, d_disk_q, d_net_q, elapsed_q;
	logic        rep_q, netchk_q;
	logic [19:0] link_q;
	logic [6:0]  cpu_pct_q, disk_pct_q;
	logic [31:0] rate_q;
	logic [22:0] mbps_q;
	logic [27:0] need_q;
	logic [127:0] dividend, quotient;
	logic [63:0]  divisor;
	logic [63:0]  d_busy, d_total, d_disk, d_net;
	logic [6:0]   pct;
	logic [15:0]  mbps_sat;
	logic [60:0]  scaled;

	always_comb begin
		d_busy = (sample.cpu_valid && cpu_primed_q && sample.cpu_busy_count >= cpu_busy_base_q)
			? sample.cpu_busy_count - cpu_busy_base_q : '0;
		d_total = (sample.cpu_valid && cpu_primed_q
			&& sample.cpu_total_count >= cpu_total_base_q)
			? sample.cpu_total_count - cpu_total_base_q : '0;
		d_disk = (sample.disk_valid && disk_primed_q && sample.disk_busy_ms >= disk_base_q)
			? sample.disk_busy_ms - disk_base_q : '0;
		d_net = (sample.net_valid && net_primed_q && sample.net_byte_count >= net_base_q)
			? sample.net_byte_count - net_base_q : '0;
	end

	always_comb begin
		unique case (cmd.div_sel)
			ucm_pkg::DIV_CPU: begin
				dividend = {64'd0, d_busy_q} * 128'(ucm_pkg::PctScale);
				divisor = d_total_q;
			end
			ucm_pkg::DIV_DISK: begin
				dividend = {64'd0, d_disk_q} * 128'(ucm_pkg::PctScale);
				divisor = elapsed_q;
			end
			default: begin
				// bits per period over elapsed ms gives kbit/s
				dividend = {61'd0, d_net_q, 3'b000};
				divisor = elapsed_q;
			end
		endcase
	end

	ucm_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start), .dividend(dividend),
		.divisor(divisor), .done(sts.div_done), .quotient(quotient)
	);

	assign pct = (quotient > 128'(ucm_pkg::PctScale)) ? 7'(ucm_pkg::PctScale) : quotient[6:0];
	// kbit/s to Mbit/s by reciprocal multiply
	assign scaled = {29'd0, rate_q} * {32'd0, ucm_pkg::MbpsRecip};
	assign mbps_sat = (mbps_q > 23'(ucm_pkg::RateMax)) ? 16'(ucm_pkg::RateMax) : mbps_q[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			any_primed_q <= 1'b0;
			cpu_primed_q <= 1'b0;
			disk_primed_q <= 1'b0;
			net_primed_q <= 1'b0;
			cpu_busy_base_q <= '0;
			cpu_total_base_q <= '0;
			disk_base_q <= '0;
			net_base_q <= '0;
			last_time_q <= '0;
		end else if (cmd.load) begin
			if (sample.cpu_valid) begin
				cpu_busy_base_q <= sample.cpu_busy_count;
				cpu_total_base_q <= sample.cpu_total_count;
			end
			if (sample.disk_valid) disk_base_q <= sample.disk_busy_ms;
			if (sample.net_valid) net_base_q <= sample.net_byte_count;
			cpu_primed_q <= sample.cpu_valid;
			disk_primed_q <= sample.disk_valid;
			net_primed_q <= sample.net_valid;
			last_time_q <= sample.now_ms;
			any_primed_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rep_q <= any_primed_q;
			d_busy_q <= d_busy;
			d_total_q <= d_total;
			d_disk_q <= d_disk;
			d_net_q <= d_net;
			elapsed_q <= (sample.now_ms > last_time_q) ? sample.now_ms - last_time_q : 64'd1;
			netchk_q <= sample.net_valid && net_primed_q;
			link_q <= (sample.link_speed_mbps != '0) ? sample.link_speed_mbps : capacity;
		end
		if (cmd.div_store) begin
			unique case (cmd.div_sel)
				ucm_pkg::DIV_CPU: cpu_pct_q <= (d_total_q == '0) ? 7'd0 : pct;
				ucm_pkg::DIV_DISK: disk_pct_q <= pct;
				// at 2^32 kbit/s and above the rate saturates and beats any
				// link threshold, so clamping here changes neither field
				default: rate_q <= (quotient[127:32] != '0) ? 32'hFFFF_FFFF
					: quotient[31:0];
			endcase
		end
		if (cmd.scale) mbps_q <= scaled[60:38];
		need_q <= {8'd0, link_q} * {21'd0, threshold};
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			report.report_valid <= rep_q;
			report.cpu_pct <= rep_q ? cpu_pct_q : '0;
			report.cpu_hot <= rep_q && d_total_q != '0 && cpu_pct_q >= threshold;
			report.disk_busy_pct <= rep_q ? disk_pct_q : '0;
			report.disk_hot <= rep_q && disk_pct_q >= threshold;
			report.net_rate <= rep_q ? mbps_sat : '0;
			report.net_hot <= rep_q && netchk_q && link_q != '0
				&& {7'd0, mbps_q} * 30'(ucm_pkg::PctScale) >= {2'd0, need_q};
		end
	end
endmodule

// ===== rtl/ucm_ctrl.sv =====
`timescale 1ns / 1ps
module ucm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output ucm_pkg::ucm_cmd_t cmd,
	input  ucm_pkg::ucm_sts_t sts
);
	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_KICK  = 6'b000010,
		ST_WAIT  = 6'b000100,
		ST_SCALE = 6'b001000,
		ST_FIN   = 6'b010000,
		ST_OUT   = 6'b100000
	} state_t;

	state_t state_q;
	ucm_pkg::div_sel_t sel_q;

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);

	always_comb begin
		cmd = '0;
		cmd.div_sel = sel_q;
		cmd.load = in_valid && in_ready;
		cmd.div_start = (state_q == ST_KICK);
		cmd.div_store = (state_q == ST_WAIT) && sts.div_done;
		cmd.scale = (state_q == ST_SCALE);
		cmd.finish = (state_q == ST_FIN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sel_q <= ucm_pkg::DIV_CPU;
		end else begin
			unique case (state_q)
				ST_IDLE: if (in_valid) begin
					state_q <= ST_KICK;
					sel_q <= ucm_pkg::DIV_CPU;
				end
				ST_KICK: state_q <= ST_WAIT;
				ST_WAIT: if (sts.div_done) begin
					if (sel_q == ucm_pkg::DIV_NET) state_q <= ST_SCALE;
					else begin
						sel_q <= ucm_pkg::div_sel_t'(sel_q + 2'd1);
						state_q <= ST_KICK;
					end
				end
				ST_SCALE: state_q <= ST_FIN;
				ST_FIN: state_q <= ST_OUT;
				ST_OUT: if (out_ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ===== rtl/utilization_congestion_monitor.sv =====
`timescale 1ns / 1ps
// Utilization and congestion monitor. Each accepted item is one sample of absolute
// cpu, disk and network counters; the block keeps baselines and primed flags per source
// and returns one report item per sample: cpu and disk busy percent (capped at 100),
// network rate in Mbit/s (saturated at 65535) and congestion flags against the threshold
// register. The first sample after reset gives an all-zero report. One item is processed
// at a time: three divisions run back to back on one shared 128-bit bit-serial divider,
// a scale step converts the rate to Mbit/s and a finish step registers the report, and
// the next input item is taken only after that report item has been accepted. Registers:
// threshold percent at 0x0, link capacity in Mbit/s (used when a sample reports link
// speed 0) at 0x4; write only while idle.
module utilization_congestion_monitor (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  ucm_pkg::sample_t in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output ucm_pkg::report_t out_data,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [2:2]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	ucm_pkg::ucm_cmd_t cmd;
	ucm_pkg::ucm_sts_t sts;
	logic [6:0]  threshold_q;
	logic [19:0] capacity_q;

	// configuration registers
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= ucm_pkg::ThresholdReset;
			capacity_q <= ucm_pkg::CapacityReset;
		end else if (psel && penable && pwrite) begin
			if (paddr == ucm_pkg::RegThreshold) threshold_q <= pwdata[6:0];
			else capacity_q <= pwdata[19:0];
		end
	end
	assign prdata = (paddr == ucm_pkg::RegThreshold) ? {25'd0, threshold_q} : {12'd0, capacity_q};

	ucm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .sts(sts)
	);

	ucm_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .sample(in_data),
		.threshold(threshold_q), .capacity(capacity_q), .report(out_data)
	);
endmodule

// ===== rtl/ucm_checker.sv =====
`timescale 1ns / 1ps
module ucm_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input ucm_pkg::report_t out_data
);
	// one item at a time: no input taken while a report waits
	a_excl: assert property (@(posedge clk) disable iff (!arst_n) !(in_ready && out_valid))
		else $error("input ready while report pending");
	a_acc: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("accepted twice");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("report dropped");
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.cpu_pct <= 7'd100 && out_data.disk_busy_pct <= 7'd100)
		else $error("percent out of range");
endmodule

bind utilization_congestion_monitor ucm_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

// ===== tb/tb_utilization_congestion_monitor.sv =====
`timescale 1ns / 1ps
module tb_utilization_congestion_monitor;
	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_ready;
	ucm_pkg::sample_t in_data;
	logic             out_valid;
	logic             out_ready;
	ucm_pkg::report_t out_data;
	logic             psel;
	logic             penable;
	logic             pwrite;
	logic [2:2]       paddr;
	logic [31:0]      pwdata;
	logic [31:0]      prdata;
	logic             pready;

	utilization_congestion_monitor uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// predictor state: thresholds, baselines and primed flags
	logic [6:0]  thr_pct;
	logic [19:0] cap_mbps;
	logic        seen_any = 1'b0, cpu_armed = 1'b0, disk_armed = 1'b0, net_armed = 1'b0;
	logic [63:0] busy_prev = '0, total_prev = '0, disk_prev = '0, net_prev = '0;
	logic [63:0] time_prev = '0;

	ucm_pkg::sample_t samples_pending[$];
	ucm_pkg::report_t reports_due[$];
	int      errors = 0;
	int      idle_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// delta of one counter, zero when not primed, invalid or going down
	function automatic logic [63:0] counter_delta(logic ok, logic armed,
			logic [63:0] cur, logic [63:0] prev);
		return (ok && armed && cur >= prev) ? cur - prev : 64'd0;
	endfunction

	// floor(num*100/den) capped at 100; den nonzero
	function automatic logic [6:0] busy_percent(logic [63:0] num, logic [63:0] den);
		logic [127:0] q;
		q = ({64'd0, num} * 128'd100) / {64'd0, den};
		return (q > 128'd100) ? 7'd100 : q[6:0];
	endfunction

	// work out the report for one sample and advance the baselines
	function automatic ucm_pkg::report_t predict_report(ucm_pkg::sample_t s);
		ucm_pkg::report_t r;
		logic [63:0] elapsed, d_busy, d_total, d_disk, d_net, link;
		logic [127:0] rate, need, min_rate;
		r = '0;
		if (seen_any) begin
			elapsed = (s.now_ms > time_prev) ? s.now_ms - time_prev : 64'd1;
			d_busy  = counter_delta(s.cpu_valid, cpu_armed, s.cpu_busy_count, busy_prev);
			d_total = counter_delta(s.cpu_valid, cpu_armed, s.cpu_total_count, total_prev);
			d_disk  = counter_delta(s.disk_valid, disk_armed, s.disk_busy_ms, disk_prev);
			d_net   = counter_delta(s.net_valid, net_armed, s.net_byte_count, net_prev);
			r.report_valid = 1'b1;
			if (d_total != 0) begin
				r.cpu_pct = busy_percent(d_busy, d_total);
				r.cpu_hot = ({1'b0, r.cpu_pct} >= {1'b0, thr_pct});
			end
			r.disk_busy_pct = busy_percent(d_disk, elapsed);
			r.disk_hot = (r.disk_busy_pct >= thr_pct);
			rate = (({64'd0, d_net} * 128'd8) / {64'd0, elapsed}) / 128'd1000;
			r.net_rate = (rate > 128'd65535) ? 16'hFFFF : rate[15:0];
			link = 64'd0;
			if (s.net_valid && net_armed)
				link = (s.link_speed_mbps != 0) ? {44'd0, s.link_speed_mbps}
					: {44'd0, cap_mbps};
			if (link != 0) begin
				need = {64'd0, link} * {121'd0, thr_pct};
				min_rate = (need + 128'd99) / 128'd100;
				r.net_hot = (rate >= min_rate);
			end
		end
		if (s.cpu_valid) begin
			busy_prev  = s.cpu_busy_count;
			total_prev = s.cpu_total_count;
		end
		if (s.disk_valid) disk_prev = s.disk_busy_ms;
		if (s.net_valid) net_prev = s.net_byte_count;
		cpu_armed  = s.cpu_valid;
		disk_armed = s.disk_valid;
		net_armed  = s.net_valid;
		time_prev  = s.now_ms;
		seen_any   = 1'b1;
		return r;
	endfunction

	// input item taken at the last rising edge
	logic in_fire;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) in_fire <= 1'b0;
		else in_fire <= in_valid && in_ready;
	end

	// driver: random gap before each item, valid held until accepted
	int gap_left;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data  <= '0;
			gap_left <= 0;
		end else if (in_valid && !in_fire) begin
			// hold item
		end else if (gap_left > 0) begin
			in_valid <= 1'b0;
			gap_left <= gap_left - 1;
		end else if (samples_pending.size() > 0) begin
			in_data  <= samples_pending.pop_front();
			in_valid <= 1'b1;
			gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
		end else begin
			in_valid <= 1'b0;
		end
	end

	// sink stall, redrawn after each report item
	int stall_left;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready  <= 1'b0;
			stall_left <= 0;
		end else if (out_valid && out_ready) begin
			stall_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
			out_ready  <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready  <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// monitor: predict on input acceptance, compare on output acceptance
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				reports_due.push_back(predict_report(in_data));
			if (out_valid && out_ready) begin
				if (reports_due.size() == 0) begin
					$display("%0t: unexpected report item %p", $realtime, out_data);
					errors++;
				end else if (reports_due[0] != out_data) begin
					$display("%0t: report mismatch exp %p got %p", $realtime,
						reports_due[0], out_data);
					errors++;
					void'(reports_due.pop_front());
				end else begin
					void'(reports_due.pop_front());
				end
			end
			// watchdog: counts cycles with no item accepted on either side, fails past its limit
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles > 5000) begin
				$display("%0t: watchdog expired", $realtime);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	task automatic apb_write(logic [2:2] addr, logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= addr; pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (addr == ucm_pkg::RegThreshold) thr_pct = value[6:0];
		else cap_mbps = value[19:0];
	endtask

	// wait until every report item is back, then let the block settle
	task automatic drain_reports();
		while (samples_pending.size() > 0 || in_valid || reports_due.size() > 0)
			@(posedge clk);
		repeat (600) @(posedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// counters advance by random steps; occasional wraps, decreases, invalid reads
	logic [63:0] c_busy, c_total, c_disk, c_net, c_now;
	function automatic ucm_pkg::sample_t next_sample();
		ucm_pkg::sample_t s;
		logic [63:0] dt;
		int          mode;
		mode = $urandom_range(0, 19);
		dt = (mode == 0) ? 64'd0 : {32'd0, $urandom_range(1, 5000)};
		c_now   = (mode == 1) ? c_now - {32'd0, $urandom_range(0, 100)} : c_now + dt;
		c_total = c_total + {32'd0, $urandom_range(0, 2000)};
		c_busy  = c_busy + {32'd0, $urandom_range(0, 2200)};
		c_disk  = c_disk + {32'd0, $urandom_range(0, 6000)};
		c_net   = c_net + ((mode < 6) ? rand64() >> $urandom_range(0, 63)
			: {32'd0, $urandom});
		if (mode == 2) c_disk = c_disk - 64'd50;
		if (mode == 3) c_net = rand64();
		if (mode == 4) begin
			c_busy = rand64(); c_total = rand64();
		end
		s.cpu_valid       = ($urandom_range(0, 7) != 0);
		s.cpu_busy_count  = c_busy;
		s.cpu_total_count = c_total;
		s.disk_valid      = ($urandom_range(0, 7) != 0);
		s.disk_busy_ms    = c_disk;
		s.net_valid       = ($urandom_range(0, 7) != 0);
		s.net_byte_count  = c_net;
		s.now_ms          = c_now;
		s.link_speed_mbps = ($urandom_range(0, 2) == 0) ? 20'd0
			: (mode == 5) ? 20'd1000000 : 20'($urandom_range(1, 100000));
		return s;
	endfunction

	ucm_pkg::sample_t d;
	initial begin
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		thr_pct = ucm_pkg::ThresholdReset; cap_mbps = ucm_pkg::CapacityReset;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: first sample, extremes, decreases, stalled time, cap cases
		d = '0; d.cpu_valid = 1; d.disk_valid = 1; d.net_valid = 1;
		samples_pending.push_back(d);
		d.cpu_busy_count = 64'd50; d.cpu_total_count = 64'd100; d.disk_busy_ms = 64'd900;
		d.net_byte_count = 64'd12500000; d.now_ms = 64'd1000;
		samples_pending.push_back(d);
		// busy above total, disk above elapsed, time not advancing
		d.cpu_busy_count = 64'd500; d.cpu_total_count = 64'd110; d.disk_busy_ms = 64'd5000;
		d.net_byte_count = '1; samples_pending.push_back(d);
		// counters going down, zero total delta
		d.cpu_busy_count = 64'd1; d.disk_busy_ms = 64'd0; d.net_byte_count = 64'd0;
		d.now_ms = '1; d.link_speed_mbps = 20'd1000000; samples_pending.push_back(d);
		// all ones
		d = '1; d.link_speed_mbps = 20'd1000000; samples_pending.push_back(d);
		d = '0; d.now_ms = 64'd5; samples_pending.push_back(d);
		d.cpu_valid = 1; d.net_valid = 1; samples_pending.push_back(d);
		d.cpu_busy_count = '1; d.cpu_total_count = '1; d.net_byte_count = '1;
		d.now_ms = 64'd6; d.disk_valid = 1; samples_pending.push_back(d);
		drain_reports();

		// sweep register settings, extremes included
		c_busy = 0; c_total = 0; c_disk = 0; c_net = 0; c_now = 0;
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin
					apb_write(ucm_pkg::RegThreshold, 32'd1);
					apb_write(ucm_pkg::RegCapacity, 32'd1);
				end
				1: begin
					apb_write(ucm_pkg::RegThreshold, 32'd100);
					apb_write(ucm_pkg::RegCapacity, 32'd1000000);
				end
				2: begin
					apb_write(ucm_pkg::RegThreshold, 32'd0);
					apb_write(ucm_pkg::RegCapacity, 32'hFFFFF);
				end
				3: begin
					apb_write(ucm_pkg::RegThreshold, 32'd127);
					apb_write(ucm_pkg::RegCapacity, 32'd0);
				end
				4: begin
					apb_write(ucm_pkg::RegThreshold, 32'($urandom_range(1, 100)));
					apb_write(ucm_pkg::RegCapacity, $urandom);
				end
				default: begin
					apb_write(ucm_pkg::RegThreshold, 32'd80);
					apb_write(ucm_pkg::RegCapacity, 32'd100);
				end
			endcase
			for (int n = 0; n < 66; n++)
				samples_pending.push_back(next_sample());
			drain_reports();
		end
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule
